/* sv/signed_multiply_divide_defines.svh */
// assertion macros for the signed multiply-divide block
`ifndef SIGNED_MULTIPLY_DIVIDE_DEFINES_SVH
`define SIGNED_MULTIPLY_DIVIDE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smd assertion failed");

// next-cycle implication, disabled in reset
`define SMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smd assertion failed");

`endif

/* sv/smd_pkg.sv */
// shared types and constants for the signed multiply-divide block
package smd_pkg;

  localparam int FIELD_BITS = 32;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] multiplicand;
    logic signed [FIELD_BITS-1:0] multiplier;
    logic signed [FIELD_BITS-1:0] divisor;
  } in_beat_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] quotient;
    logic signed [FIELD_BITS-1:0] remainder;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic fix;
  } dp_cmd_t;

endpackage

/* sv/signed_multiply_divide.sv */
// top level of the signed multiply-divide block
//
//   channel   ports                  handshake
//   input     in_beat                start high while busy low
//   result    out_beat               out_valid, one cycle, no back-pressure
//
// an item takes 2*WORD_BITS+2 cycles from accept to its result cycle:
// one multiply cycle, 2*WORD_BITS restoring divider steps (one dividend bit
// each), and one sign fix-up cycle
// busy is low in the result cycle, so the next beat may be taken there
// reset is synchronous and active low; it returns the controller to idle
module signed_multiply_divide
  import smd_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  output out_beat_t out_beat
);

  dp_cmd_t cmd;

  smd_ctrl #(
    .WORD_BITS(WORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  smd_dp #(
    .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .in_beat (in_beat),
    .out_beat(out_beat)
  );

endmodule

/* sv/smd_ctrl.sv */
// controller state machine sequencing load, multiply, divide and sign fix-up
module smd_ctrl
  import smd_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  localparam int STEPS = 2 * WORD_BITS;
  localparam int CNT_W = $clog2(STEPS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIX  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_step;

  assign last_step = (cnt_r == CNT_W'(STEPS - 1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (last_step) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign cmd.load  = (state_r == ST_IDLE) && start;
  assign cmd.mul   = (state_r == ST_MUL);
  assign cmd.step  = (state_r == ST_DIV);
  assign cmd.fix   = (state_r == ST_FIX);

endmodule

/* sv/smd_dp.sv */
// datapath: magnitudes, product, restoring divider and sign fix-up
module smd_dp
  import smd_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  dp_cmd_t   cmd,
  input  in_beat_t  in_beat,
  output out_beat_t out_beat
);

  localparam int W = WORD_BITS;

  logic [W-1:0]   a_raw, b_raw, c_raw;
  logic [W-1:0]   ma_nxt, mb_nxt, mc_mag, mc_nxt;
  logic [W-1:0]   ma_r, mb_r, mc_r;
  logic           rneg_r, qneg_r;
  logic [2*W-1:0] prod_r;
  logic [W-1:0]   rem_r, quo_r;
  logic [W-1:0]   rem_sh, rem_nxt, quo_nxt;
  logic           ge;
  logic [W-1:0]   quo_fix, rem_fix;
  logic signed [W-1:0] quo_s, rem_s;
  out_beat_t      out_r;

  assign a_raw  = in_beat.multiplicand[W-1:0];
  assign b_raw  = in_beat.multiplier[W-1:0];
  assign c_raw  = in_beat.divisor[W-1:0];
  assign ma_nxt = a_raw[W-1] ? (~a_raw + W'(1)) : a_raw;
  assign mb_nxt = b_raw[W-1] ? (~b_raw + W'(1)) : b_raw;
  assign mc_mag = c_raw[W-1] ? (~c_raw + W'(1)) : c_raw;
  // zero divisor acts as one
  assign mc_nxt = (mc_mag == '0) ? W'(1) : mc_mag;

  // remainder stays below the divisor magnitude, so its top bit is free
  assign rem_sh  = {rem_r[W-2:0], prod_r[2*W-1]};
  assign ge      = (rem_sh >= mc_r);
  assign rem_nxt = ge ? (rem_sh - mc_r) : rem_sh;
  assign quo_nxt = {quo_r[W-2:0], ge};

  assign quo_fix = qneg_r ? (~quo_r + W'(1)) : quo_r;
  assign rem_fix = rneg_r ? (~rem_r + W'(1)) : rem_r;
  assign quo_s   = quo_fix;
  assign rem_s   = rem_fix;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ma_r   <= ma_nxt;
      mb_r   <= mb_nxt;
      mc_r   <= mc_nxt;
      rneg_r <= a_raw[W-1] ^ b_raw[W-1];
      qneg_r <= a_raw[W-1] ^ b_raw[W-1] ^ c_raw[W-1];
    end
    if (cmd.mul) begin
      prod_r <= ma_r * mb_r;
      rem_r  <= '0;
      quo_r  <= '0;
    end
    if (cmd.step) begin
      prod_r <= {prod_r[2*W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
    end
    if (cmd.fix) begin
      out_r.quotient  <= FIELD_BITS'(quo_s);
      out_r.remainder <= FIELD_BITS'(rem_s);
    end
  end

  assign out_beat = out_r;

endmodule

/* sv/smd_checker.sv */
// port-level checker for the signed multiply-divide block and its bind
`include "signed_multiply_divide_defines.svh"

module smd_checker
  import smd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_beat_t out_beat
);

  `SMD_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy && !out_valid)
  `SMD_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `SMD_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid, !busy)
  `SMD_ASSERT_IMP(a_done_strobe, clk, rst_n, $fell(busy), out_valid)
  `SMD_ASSERT_IMP(a_result_known, clk, rst_n, out_valid, !$isunknown(out_beat))

endmodule

bind signed_multiply_divide smd_checker u_smd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_beat (out_beat)
);

/* bench/signed_multiply_divide_tb.sv */
// testbench for the signed multiply-divide block: directed and random operands checked per beat
module signed_multiply_divide_tb
  import smd_pkg::*;
();

  localparam int W = FIELD_BITS;
  localparam logic signed [W-1:0] CORNER_WORDS [6] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000,
    32'sh0000_0001, 32'shffff_ffff, 32'sh8000_0001
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  out_beat_t out_beat;

  out_beat_t pending_quot_rem [$];
  int        error_count = 0;
  bit        idling_on = 1'b1;

  signed_multiply_divide dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_beat(in_beat),
    .out_valid(out_valid),
    .out_beat(out_beat)
  );

  always #6 clk = ~clk;

  initial begin
    #8000000;
    $display("signed_multiply_divide_tb failed");
    $finish;
  end

  task automatic flag_error(string what, logic [W-1:0] got, logic [W-1:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  function automatic out_beat_t muldiv_quot_rem(in_beat_t b);
    logic [W-1:0]   mag_a, mag_b, mag_c;
    logic [2*W-1:0] prod, quot, rem;
    logic           neg_a, neg_b, neg_c, rem_neg, quot_neg;
    out_beat_t      res;
    neg_a = b.multiplicand[W-1];
    neg_b = b.multiplier[W-1];
    neg_c = b.divisor[W-1];
    mag_a = neg_a ? ~b.multiplicand + 1'b1 : b.multiplicand;
    mag_b = neg_b ? ~b.multiplier + 1'b1 : b.multiplier;
    mag_c = neg_c ? ~b.divisor + 1'b1 : b.divisor;
    if (mag_c == '0) mag_c = W'(1);
    prod = {{W{1'b0}}, mag_a} * {{W{1'b0}}, mag_b};
    quot = prod / {{W{1'b0}}, mag_c};
    rem  = prod % {{W{1'b0}}, mag_c};
    rem_neg  = neg_a ^ neg_b;
    quot_neg = rem_neg ^ neg_c;
    if (quot_neg) quot = ~quot + 1'b1;
    if (rem_neg) rem = ~rem + 1'b1;
    res.quotient  = quot[W-1:0];
    res.remainder = rem[W-1:0];
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid) begin
      if (pending_quot_rem.size() == 0) begin
        flag_error("unexpected beat, quotient", out_beat.quotient, 'x);
      end else begin
        want = pending_quot_rem.pop_front();
        if (out_beat.quotient !== want.quotient)
          flag_error("quotient", out_beat.quotient, want.quotient);
        if (out_beat.remainder !== want.remainder)
          flag_error("remainder", out_beat.remainder, want.remainder);
      end
    end
  end

  // called at a rising edge; returns at the edge that takes the beat
  task automatic send_beat(in_beat_t b);
    start   <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (busy);
    pending_quot_rem.push_back(muldiv_quot_rem(b));
  endtask

  task automatic send_ops(logic signed [W-1:0] a, logic signed [W-1:0] b,
                          logic signed [W-1:0] c);
    in_beat_t beat;
    beat.multiplicand = a;
    beat.multiplier   = b;
    beat.divisor      = c;
    send_beat(beat);
  endtask

  task automatic maybe_idle();
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      // sometimes let the block finish and sit idle first
      if ($urandom_range(0, 1))
        do @(posedge clk); while (busy);
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_quot_rem.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [W-1:0] rand_word();
    logic signed [W-1:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom;
      3:       v = $signed($urandom_range(0, 400)) - 200;
      4:       v = CORNER_WORDS[$urandom_range(0, 5)];
      5:       v = $signed($urandom) >>> $urandom_range(1, 30);
      6:       v = 32'sd1 <<< $urandom_range(0, W - 1);
      default: v = -(32'sd1 <<< $urandom_range(0, W - 2));
    endcase
    return v;
  endfunction

  task automatic send_random();
    logic signed [W-1:0] a, b, c;
    a = rand_word();
    b = rand_word();
    case ($urandom_range(0, 7))
      0:       c = '0;
      1:       c = a;
      2:       c = b + ($signed($urandom_range(0, 6)) - 3);
      3:       c = $urandom;
      default: c = rand_word();
    endcase
    send_ops(a, b, c);
  endtask

  task automatic test_directed();
    send_ops(0, 0, 0);
    send_ops(1, 1, 1);
    send_ops(7, 3, 2);
    send_ops(-7, 3, 2);
    send_ops(7, -3, 2);
    send_ops(7, 3, -2);
    send_ops(-7, -3, 2);
    send_ops(-7, 3, -2);
    send_ops(7, -3, -2);
    send_ops(-7, -3, -2);
    // zero divisor
    send_ops(12345, -678, 0);
    send_ops(32'sh7fff_ffff, 32'sh7fff_ffff, 0);
    // quotient overflow
    send_ops(32'sh8000_0000, 32'sh8000_0000, 1);
    send_ops(32'sh8000_0000, 32'sh8000_0000, -1);
    send_ops(32'sh7fff_ffff, 32'sh7fff_ffff, 1);
    send_ops(32'sh8000_0000, 1, -1);
    // most negative and other corner operands
    send_ops(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_ops(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    send_ops(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
    send_ops(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_ops(32'sh8000_0001, 32'sh7fff_fffe, 32'sh8000_0001);
    send_ops(-1, -1, 32'sh8000_0000);
    send_ops(0, 32'sh8000_0000, -1);
    send_ops(32'sh5555_aaaa, 32'shaaaa_5555, 32'sh0f0f_f0f0);
    wait_drained();
  endtask

  task automatic test_random_idling(int count);
    repeat (count) begin
      send_random();
      maybe_idle();
    end
  endtask

  task automatic test_drain_pause();
    repeat (40) send_random();
    wait_drained();
    repeat (40) begin
      send_random();
      maybe_idle();
    end
  endtask

  task automatic test_back_to_back(int count);
    idling_on = 1'b0;
    repeat (count) send_random();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_idling(1100);
    test_drain_pause();
    test_back_to_back(500);
    start <= 1'b0;
    while (pending_quot_rem.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
    if (error_count == 0)
      $display("signed_multiply_divide_tb passed");
    else
      $display("signed_multiply_divide_tb failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/smd_pkg.sv
sv/smd_ctrl.sv
sv/smd_dp.sv
sv/signed_multiply_divide.sv
sv/smd_checker.sv
bench/signed_multiply_divide_tb.sv
